// ===== rtl/core/wsp_pkg.sv =====
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared types and constants of the WAV stream parser.
// ----------------------------------------------------------------------------
`default_nettype none

package wsp_pkg;

   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;
   localparam logic [31:0] FMT_SIZE = 32'd16;

   localparam int FRAME_POS_W = 17;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_WAVE   = 3'd1,
      PH_FMT    = 3'd2,
      PH_DATA   = 3'd3,
      PH_SKIP   = 3'd4,
      PH_PAD    = 3'd5,
      PH_STOP   = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      EV_FRAME  = 2'd0,
      EV_FORMAT = 2'd1,
      EV_ERROR  = 2'd2
   } event_kind_type;

   typedef struct packed {
      logic [7:0] file_byte;
      logic       start_of_file;
   } item_type;

   typedef struct packed {
      logic                valid;
      event_kind_type      kind;
      logic signed [15:0]  left_sample;
      logic signed [15:0]  right_sample;
      logic [31:0]         sample_rate;
      logic [15:0]         channel_count;
      logic [15:0]         sample_bits;
   } event_type;

endpackage

`default_nettype wire

// ===== rtl/core/wsp_in_reg.sv =====
// ----------------------------------------------------------------------------
// wsp_in_reg
// Input register: holds one byte item until the parse stage consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module wsp_in_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,
   input  wire logic              req_tuser,
   input  wire logic              advance,
   output logic                   item_valid,
   output wsp_pkg::item_type      item
);

   logic              valid_ff;
   logic              valid_in;
   wsp_pkg::item_type item_ff;

   assign req_tready = !valid_ff || advance;
   assign valid_in   = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.file_byte     <= req_tdata;
         item_ff.start_of_file <= req_tuser;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ===== rtl/core/wsp_parse_core.sv =====
// ----------------------------------------------------------------------------
// wsp_parse_core
// Chunk parser state and the one-step update for a single file byte.
// ----------------------------------------------------------------------------
`default_nettype none

module wsp_parse_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step_en,
   input  wire wsp_pkg::item_type item,
   output wsp_pkg::event_type     evt
);

   wsp_pkg::phase_type phase_ff, phase_in, cur_phase;
   logic [3:0]   pos_ff, pos_in, cur_pos;
   logic [31:0]  tag_ff, tag_in, cur_tag;
   logic [31:0]  len_ff, len_in, cur_len;
   logic         fmt_seen_ff, fmt_seen_in, cur_fmt_seen;
   logic [15:0]  chan_ff, chan_in, cur_chan;
   logic [31:0]  rate_ff, rate_in, cur_rate;
   logic [15:0]  depth_ff, depth_in, cur_depth;
   logic [wsp_pkg::FRAME_POS_W-1:0] fpos_ff, fpos_in, cur_fpos;
   logic [wsp_pkg::FRAME_POS_W-1:0] fbytes_ff, fbytes_in, cur_fbytes;
   logic         pad_ff, pad_in, cur_pad;
   logic [7:0]   low_ff, low_in, cur_low;
   logic [15:0]  left_ff, left_in, cur_left;
   logic [15:0]  right_ff, right_in, cur_right;

   logic         sof;
   logic [7:0]   b;
   logic [31:0]  len_dec;
   logic         body_last;
   logic [wsp_pkg::FRAME_POS_W:0] fpos_inc;
   logic         frame_done;
   logic         depth_ok;

   assign sof = item.start_of_file;
   assign b   = item.file_byte;

   // a start flag makes this byte see the post-reset state
   assign cur_phase    = sof ? wsp_pkg::PH_HEADER : phase_ff;
   assign cur_pos      = sof ? '0 : pos_ff;
   assign cur_tag      = sof ? '0 : tag_ff;
   assign cur_len      = sof ? '0 : len_ff;
   assign cur_fmt_seen = sof ? 1'b0 : fmt_seen_ff;
   assign cur_chan     = sof ? '0 : chan_ff;
   assign cur_rate     = sof ? '0 : rate_ff;
   assign cur_depth    = sof ? '0 : depth_ff;
   assign cur_fpos     = sof ? '0 : fpos_ff;
   assign cur_fbytes   = sof ? '0 : fbytes_ff;
   assign cur_pad      = sof ? 1'b0 : pad_ff;
   assign cur_low      = sof ? '0 : low_ff;
   assign cur_left     = sof ? '0 : left_ff;
   assign cur_right    = sof ? '0 : right_ff;

   assign len_dec    = cur_len - 32'd1;
   assign body_last  = (len_dec == 32'd0);
   assign fpos_inc   = {1'b0, cur_fpos} + {{wsp_pkg::FRAME_POS_W{1'b0}}, 1'b1};
   assign frame_done = (fpos_inc >= {1'b0, cur_fbytes});
   assign depth_ok   = ((cur_depth == 16'd8) || (cur_depth == 16'd16)) && (cur_chan != 16'd0);

   always_comb begin
      phase_in    = cur_phase;
      pos_in      = cur_pos;
      tag_in      = cur_tag;
      len_in      = cur_len;
      fmt_seen_in = cur_fmt_seen;
      chan_in     = cur_chan;
      rate_in     = cur_rate;
      depth_in    = cur_depth;
      fpos_in     = cur_fpos;
      fbytes_in   = cur_fbytes;
      pad_in      = cur_pad;
      low_in      = cur_low;
      left_in     = cur_left;
      right_in    = cur_right;
      evt         = '0;

      unique case (cur_phase)
         wsp_pkg::PH_HEADER: begin
            if (!cur_pos[2]) begin
               if (cur_pos == 4'd0) begin
                  tag_in = '0;
               end
               tag_in[8*cur_pos[1:0] +: 8] = tag_in[8*cur_pos[1:0] +: 8] | b;
            end else begin
               if (cur_pos == 4'd4) begin
                  len_in = '0;
               end
               len_in[8*cur_pos[1:0] +: 8] = len_in[8*cur_pos[1:0] +: 8] | b;
            end
            if (cur_pos >= 4'd7) begin
               pos_in = '0;
               if (tag_in == wsp_pkg::TAG_RIFF) begin
                  tag_in   = '0;
                  phase_in = wsp_pkg::PH_WAVE;
               end else if (tag_in == wsp_pkg::TAG_FMT) begin
                  if (len_in != wsp_pkg::FMT_SIZE) begin
                     phase_in  = wsp_pkg::PH_STOP;
                     evt.valid = 1'b1;
                     evt.kind  = wsp_pkg::EV_ERROR;
                  end else begin
                     phase_in = wsp_pkg::PH_FMT;
                  end
               end else if (tag_in == wsp_pkg::TAG_DATA && !cur_fmt_seen) begin
                  phase_in  = wsp_pkg::PH_STOP;
                  evt.valid = 1'b1;
                  evt.kind  = wsp_pkg::EV_ERROR;
               end else begin
                  // data with a usable format, or a chunk to skip
                  if (tag_in == wsp_pkg::TAG_DATA && depth_ok) begin
                     fbytes_in = (cur_depth == 16'd16) ? {cur_chan, 1'b0} : {1'b0, cur_chan};
                     fpos_in   = '0;
                  end
                  if (len_in == 32'd0) begin
                     phase_in = wsp_pkg::PH_HEADER;
                  end else begin
                     pad_in   = len_in[0];
                     phase_in = (tag_in == wsp_pkg::TAG_DATA && depth_ok) ?
                                wsp_pkg::PH_DATA : wsp_pkg::PH_SKIP;
                  end
               end
            end else begin
               pos_in = cur_pos + 4'd1;
            end
         end

         wsp_pkg::PH_WAVE: begin
            tag_in[8*cur_pos[1:0] +: 8] = tag_in[8*cur_pos[1:0] +: 8] | b;
            if (cur_pos >= 4'd3) begin
               pos_in = '0;
               if (tag_in != wsp_pkg::TAG_WAVE) begin
                  phase_in  = wsp_pkg::PH_STOP;
                  evt.valid = 1'b1;
                  evt.kind  = wsp_pkg::EV_ERROR;
               end else begin
                  phase_in = wsp_pkg::PH_HEADER;
               end
            end else begin
               pos_in = cur_pos + 4'd1;
            end
         end

         wsp_pkg::PH_FMT: begin
            case (cur_pos)
               4'd2:  chan_in[7:0]   = b;
               4'd3:  chan_in[15:8]  = b;
               4'd4, 4'd5, 4'd6, 4'd7: rate_in[8*cur_pos[1:0] +: 8] = b;
               4'd14: depth_in[7:0]  = b;
               4'd15: depth_in[15:8] = b;
               default: ;
            endcase
            if (cur_pos == 4'd15) begin
               pos_in            = '0;
               fmt_seen_in       = 1'b1;
               phase_in          = wsp_pkg::PH_HEADER;
               evt.valid         = 1'b1;
               evt.kind          = wsp_pkg::EV_FORMAT;
               evt.sample_rate   = rate_in;
               evt.channel_count = chan_in;
               evt.sample_bits   = depth_in;
            end else begin
               pos_in = cur_pos + 4'd1;
            end
         end

         wsp_pkg::PH_DATA: begin
            if (cur_depth == 16'd8) begin
               // unsigned 8-bit to signed, scaled into the upper byte
               if (cur_fpos == '0) begin
                  left_in = {b ^ 8'h80, 8'h00};
               end else if (cur_fpos == {{(wsp_pkg::FRAME_POS_W-1){1'b0}}, 1'b1}) begin
                  right_in = {b ^ 8'h80, 8'h00};
               end
            end else begin
               case (cur_fpos)
                  17'd0, 17'd2: low_in   = b;
                  17'd1:        left_in  = {b, cur_low};
                  17'd3:        right_in = {b, cur_low};
                  default: ;
               endcase
            end
            if (frame_done) begin
               fpos_in          = '0;
               evt.valid        = 1'b1;
               evt.kind         = wsp_pkg::EV_FRAME;
               evt.left_sample  = left_in;
               evt.right_sample = (cur_chan == 16'd1) ? left_in : right_in;
            end else begin
               fpos_in = fpos_inc[wsp_pkg::FRAME_POS_W-1:0];
            end
            len_in = len_dec;
            if (body_last) begin
               pos_in   = '0;
               phase_in = cur_pad ? wsp_pkg::PH_PAD : wsp_pkg::PH_HEADER;
               pad_in   = 1'b0;
            end
         end

         wsp_pkg::PH_SKIP: begin
            len_in = len_dec;
            if (body_last) begin
               pos_in   = '0;
               phase_in = cur_pad ? wsp_pkg::PH_PAD : wsp_pkg::PH_HEADER;
               pad_in   = 1'b0;
            end
         end

         wsp_pkg::PH_PAD: begin
            pos_in   = '0;
            phase_in = wsp_pkg::PH_HEADER;
         end

         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= wsp_pkg::PH_HEADER;
         pos_ff      <= '0;
         tag_ff      <= '0;
         len_ff      <= '0;
         fmt_seen_ff <= 1'b0;
         chan_ff     <= '0;
         rate_ff     <= '0;
         depth_ff    <= '0;
         fpos_ff     <= '0;
         fbytes_ff   <= '0;
         pad_ff      <= 1'b0;
         low_ff      <= '0;
         left_ff     <= '0;
         right_ff    <= '0;
      end else if (step_en) begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         tag_ff      <= tag_in;
         len_ff      <= len_in;
         fmt_seen_ff <= fmt_seen_in;
         chan_ff     <= chan_in;
         rate_ff     <= rate_in;
         depth_ff    <= depth_in;
         fpos_ff     <= fpos_in;
         fbytes_ff   <= fbytes_in;
         pad_ff      <= pad_in;
         low_ff      <= low_in;
         left_ff     <= left_in;
         right_ff    <= right_in;
      end
   end

   a_error_stops: assert property (@(posedge clock) disable iff (reset)
      step_en && evt.valid && evt.kind == wsp_pkg::EV_ERROR |=> phase_ff == wsp_pkg::PH_STOP)
      else $error("error item did not stop the parser");

   a_format_marks_seen: assert property (@(posedge clock) disable iff (reset)
      step_en && evt.valid && evt.kind == wsp_pkg::EV_FORMAT |=> fmt_seen_ff)
      else $error("format item without format marked seen");

   a_stopped_silent: assert property (@(posedge clock) disable iff (reset)
      phase_ff == wsp_pkg::PH_STOP && !sof |-> !evt.valid)
      else $error("stopped parser produced an item");

   a_frame_in_data: assert property (@(posedge clock) disable iff (reset)
      evt.valid && evt.kind == wsp_pkg::EV_FRAME |-> cur_phase == wsp_pkg::PH_DATA)
      else $error("sample frame outside a data chunk");

endmodule

`default_nettype wire

// ===== rtl/core/wsp_out_reg.sv =====
// ----------------------------------------------------------------------------
// wsp_out_reg
// Result register: holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module wsp_out_reg (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               load,
   input  wire wsp_pkg::event_type evt,
   output logic                    out_free,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [95:0]             rsp_tdata,
   output logic [1:0]              rsp_tuser
);

   logic               valid_ff;
   logic               valid_in;
   wsp_pkg::event_type evt_ff;

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         evt_ff <= evt;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {evt_ff.sample_bits, evt_ff.channel_count, evt_ff.sample_rate,
                        evt_ff.right_sample, evt_ff.left_sample};
   assign rsp_tuser  = evt_ff.kind;

endmodule

`default_nettype wire

// ===== rtl/core/wav_stream_parser.sv =====
// path: an accepted byte is held in the input register and parsed from there; its result item is
//   then held in the result register, which drives rsp
// throughput: one byte per cycle while results are taken, set by the one-step update of the chunk state
// a byte that yields a result waits only if the result register is still full
// reset: synchronous, clears both item registers and returns the parser to the
//   chunk header phase with no format known
// ----------------------------------------------------------------------------
// wav_stream_parser
// RIFF/WAVE byte-stream parser producing format items and stereo Q1.15 frames.
// ----------------------------------------------------------------------------
`default_nettype none

module wav_stream_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] file_byte
   input  wire logic        req_tuser,   // [0] start_of_file
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [95:0]      rsp_tdata,   // [15:0] left_sample, [31:16] right_sample,
                                         // [63:32] sample_rate, [79:64] channel_count,
                                         // [95:80] sample_bits
   output logic [1:0]       rsp_tuser    // [1:0] event_kind
);

   logic               item_valid;
   wsp_pkg::item_type  item;
   wsp_pkg::event_type evt;
   logic               out_free;
   logic               advance;

   assign advance = item_valid && (!evt.valid || out_free);

   wsp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   wsp_parse_core u_parse_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item),
      .evt     (evt)
   );

   wsp_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && evt.valid),
      .evt        (evt),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire
